// ----- src/dmks_pkg.sv -----
// Package for the dual mode key scanner: sizes, status and register codes,
// the per-key memory entry type and the threshold clamp function.
// Used by dmks_step and dual_mode_key_scanner_unit.
package dmks_pkg;

    localparam int NUM_KEYS   = 16;
    localparam int COUNT_BITS = 16;
    localparam int KEY_W      = 4;
    localparam int REG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int KEY_AW     = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

    typedef enum logic [1:0] {
        ST_INVALID = 2'd0,
        ST_VALID   = 2'd1,
        ST_FAULT   = 2'd2
    } t_key_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESENT    = 3'd0,
        CFG_LATCHING   = 3'd1,
        CFG_ACTIVE_HI  = 3'd2,
        CFG_VALID_TCK  = 3'd3,
        CFG_FAULT_TCK  = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        t_key_status             status;
        logic [COUNT_BITS-1:0]   count;
    } t_key_entry;

    typedef struct packed {
        logic present;
        logic latching;
        logic pressed;
    } t_key_ctrl;

    function automatic logic [COUNT_BITS-1:0] clamp_ticks(input logic [REG_W-1:0] t);
        logic [32:0] wide;
        wide = 33'(t);
        if (wide > COUNT_MAX) begin
            return COUNT_BITS'(COUNT_MAX);
        end
        return COUNT_BITS'(wide);
    endfunction

endpackage

// ----- src/dmks_step.sv -----
// Per-key update rule: takes one key's stored entry and its qualified pin
// sample and returns the new entry. Depends on dmks_pkg.
module dmks_step import dmks_pkg::*; (
    input  t_key_entry             i_entry,
    input  t_key_ctrl              i_ctrl,
    input  logic [COUNT_BITS-1:0]  i_lim_valid,
    input  logic [COUNT_BITS-1:0]  i_lim_fault,
    output t_key_entry             o_entry
);

    logic counting;

    always_comb begin
        o_entry  = i_entry;
        counting = ((i_entry.status == ST_INVALID) && i_ctrl.pressed)
                || ((i_entry.status == ST_VALID) && !i_ctrl.pressed);
        if (!i_ctrl.present) begin
            o_entry.status = ST_FAULT;
        end else if (i_ctrl.latching) begin
            if (counting) begin
                if (i_entry.count < i_lim_valid) begin
                    o_entry.count = i_entry.count + COUNT_BITS'(1);
                end else begin
                    o_entry.status = (i_entry.status == ST_INVALID) ? ST_VALID : ST_INVALID;
                    o_entry.count  = '0;
                end
            end
        end else if (i_ctrl.pressed) begin
            if (i_entry.count < i_lim_fault) begin
                o_entry.count = i_entry.count + COUNT_BITS'(1);
            end else begin
                o_entry.status = ST_FAULT;
            end
        end else begin
            if (i_entry.status == ST_FAULT) begin
                o_entry.status = ST_INVALID;
            end else if (i_entry.count >= i_lim_valid) begin
                o_entry.status = ST_VALID;
            end else begin
                o_entry.status = ST_INVALID;
            end
            o_entry.count = '0;
        end
    end

endmodule

// ----- src/dual_mode_key_scanner_unit.sv -----
// Top level of the dual mode key scanner: per-key state memory with
// read-modify-write, forwarding, output register and configuration registers.
// Depends on dmks_pkg and dmks_step.
//
// Channel   Dir  Signals                         Request
// s         in   i_s_tvalid o_s_tready i_s_tdata  key index, pin level
// m         out  o_m_tvalid i_m_tready o_m_tdata  result index, key status
// cfg       in   i_cfg_we i_cfg_index i_cfg_data   register write
//
// One request per cycle is sustained while the output is not stalled; the memory is
// read at the accepting edge into the update stage, and the update stage registers
// the result into the output register when the output is free.
// Synchronous reset clears the control and configuration registers, but sets the
// fault tick limit to all ones, and marks every memory entry unwritten.
// A stalled output holds the update stage, and the input is held off only then.
module dual_mode_key_scanner_unit import dmks_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [3:0] key_index, [4] pin_level
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,   // [3:0] result_index, [5:4] key_status
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [REG_W-1:0]      i_cfg_data
);

    logic [REG_W-1:0] r_present, r_latching, r_active_hi, r_valid_tck, r_fault_tck;

    t_key_entry       r_mem [NUM_KEYS];
    t_key_entry       r_mem_q;
    logic [NUM_KEYS-1:0] r_written;

    logic             r_s1_valid;
    logic [KEY_W-1:0] r_s1_key;
    logic [KEY_AW-1:0] r_s1_addr;
    logic             r_s1_pin;
    logic             r_s1_in_range;
    logic             r_s1_hit;
    logic             r_fwd;
    t_key_entry       r_fwd_entry;

    logic             r_out_valid;
    logic [KEY_W-1:0] r_out_key;
    t_key_status      r_out_status;

    logic             out_free;
    logic             s1_move;
    logic             accept;
    logic             mem_we;
    logic [KEY_W-1:0] in_key;
    logic [KEY_AW-1:0] in_addr;
    logic             in_range;
    t_key_entry       cur_entry;
    t_key_entry       new_entry;
    t_key_ctrl        ctrl;

    assign in_key   = i_s_tdata[3:0];
    assign in_addr  = KEY_AW'(in_key);
    assign in_range = (32'(in_key) < 32'(NUM_KEYS));

    assign out_free   = !r_out_valid || i_m_tready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_s_tready = !r_s1_valid || out_free;
    assign accept     = i_s_tvalid && o_s_tready;
    assign mem_we     = s1_move && r_s1_in_range;

    always_comb begin
        if (r_fwd) begin
            cur_entry = r_fwd_entry;
        end else if (r_s1_hit) begin
            cur_entry = r_mem_q;
        end else begin
            cur_entry = '{status: ST_INVALID, count: '0};
        end
        ctrl.present  = r_present[r_s1_key];
        ctrl.latching = r_latching[r_s1_key];
        ctrl.pressed  = (r_active_hi[r_s1_key] == r_s1_pin);
    end

    dmks_step u_step (
        .i_entry     (cur_entry),
        .i_ctrl      (ctrl),
        .i_lim_valid (clamp_ticks(r_valid_tck)),
        .i_lim_fault (clamp_ticks(r_fault_tck)),
        .o_entry     (new_entry)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_s1_addr] <= new_entry;
        end
        if (accept) begin
            r_mem_q <= r_mem[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= '0;
            r_latching  <= '0;
            r_active_hi <= '0;
            r_valid_tck <= '0;
            r_fault_tck <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRESENT:   r_present   <= i_cfg_data;
                CFG_LATCHING:  r_latching  <= i_cfg_data;
                CFG_ACTIVE_HI: r_active_hi <= i_cfg_data;
                CFG_VALID_TCK: r_valid_tck <= i_cfg_data;
                CFG_FAULT_TCK: r_fault_tck <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written   <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (mem_we) begin
                r_written[r_s1_addr] <= 1'b1;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= mem_we && (r_s1_addr == in_addr);
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
                r_fwd      <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_key      <= in_key;
            r_s1_addr     <= in_addr;
            r_s1_pin      <= i_s_tdata[4];
            r_s1_in_range <= in_range;
            r_s1_hit      <= in_range && r_written[in_addr];
            r_fwd_entry   <= new_entry;
        end
        if (s1_move) begin
            r_out_key    <= r_s1_key;
            r_out_status <= r_s1_in_range ? new_entry.status : ST_FAULT;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_status, r_out_key};

`ifndef SYNTHESIS
    a_fwd_needs_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_valid)
        else $error("forwarding flag set with empty update stage");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> (r_s1_valid && $stable(r_s1_key)))
        else $error("update stage lost its request under stall");
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_s1_valid && r_out_valid && !i_m_tready))
        else $error("input held off without a full pipeline");
    a_no_write_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && !r_s1_in_range) |=> (o_m_tdata[5:4] == ST_FAULT))
        else $error("out-of-range key not reported as fault");
`endif

endmodule
